// ===== hw/rtl/hisamp_pkg.sv =====
// ----------------------------------------------------------------------------
// hisamp_pkg
// shared types and constants of the hermite inverse cdf sampler
// ----------------------------------------------------------------------------
`default_nettype none

package hisamp_pkg;

  typedef enum logic [1:0] {
    KIND_INV   = 2'd0,
    KIND_DENS  = 2'd1,
    KIND_GUIDE = 2'd2,
    KIND_DRAW  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GUIDE,
    S_START,
    S_FETCH,
    S_CHECK,
    S_DIV,
    S_SQ,
    S_CUBE,
    S_MULA,
    S_MULB,
    S_DONE
  } state_e;

  localparam int          CoefW     = 48;
  localparam int          BoundW    = 33;
  localparam int          DivSteps  = 32;
  localparam logic [2:0]  LastTerm  = 3'd5;
  localparam logic [32:0] OneQ32    = 33'h1_0000_0000;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         slot;
    logic [32:0]        cdf_low;
    logic [32:0]        cdf_high;
    logic signed [47:0] coef0;
    logic signed [47:0] coef1;
    logic signed [47:0] coef2;
    logic signed [47:0] coef3;
    logic [7:0]         guide_start;
    logic [31:0]        uniform;
  } in_t;

  typedef struct packed {
    logic signed [47:0] variate;
    logic signed [47:0] density;
    logic [7:0]         interval_index;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       draw_ld;
    logic       guide_ld;
    logic       step;
    logic       capture;
    logic       div_step;
    logic       sq_ld;
    logic       cube_ld;
    logic       mul_a;
    logic       mul_b;
    logic [2:0] term;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic search_more;
    logic div_needed;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hermite_inverse_cdf_sampler_top.sv =====
// ----------------------------------------------------------------------------
// hermite_inverse_cdf_sampler_top
// inverse cdf sampler with guide table, forward search and hermite cubics
//
//   channel   ports                              direction
//   item      start, busy, item_i                in
//   result    result_valid_o, result_o           out
//   config    cfg_we_i, cfg_wdata_i              in
//
// loads do not raise busy. a draw keeps busy high through the guide lookup,
// its forward search steps, the division and six multiplies, and shows its
// result in the cycle after its last busy cycle. the 32-step restoring
// divider is skipped when t needs no division: value at or below the low
// bound, at or above the high bound, or an empty interval.
// reset clears control only; tables are undefined until loaded.
// the result is shown one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hermite_inverse_cdf_sampler_top #(
  parameter int MAX_INTERVALS = 256,
  parameter int GUIDE_LENGTH  = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire hisamp_pkg::in_t  item_i,
  output hisamp_pkg::out_t      result_o,
  output logic                  result_valid_o,
  input  wire logic             cfg_we_i,
  input  wire logic [8:0]       cfg_wdata_i
);

  hisamp_pkg::cmd_t cmd;
  hisamp_pkg::sts_t sts;

  hisamp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .kind_i(item_i.kind), .sts_i(sts), .cmd_o(cmd), .busy
  );

  hisamp_dp #(.MAX_INTERVALS(MAX_INTERVALS), .GUIDE_LENGTH(GUIDE_LENGTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .item_i, .cfg_we_i, .cfg_wdata_i,
    .result_o, .result_valid_o
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hisamp_ram.sv =====
// ----------------------------------------------------------------------------
// hisamp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hisamp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hisamp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hisamp_ctrl
// sequencer for guide lookup, interval search, division and cubic terms
// ----------------------------------------------------------------------------
`default_nettype none

module hisamp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire hisamp_pkg::kind_e    kind_i,
  input  wire hisamp_pkg::sts_t     sts_i,
  output hisamp_pkg::cmd_t          cmd_o,
  output logic                      busy
);

  hisamp_pkg::state_e state_q, state_d;
  logic [4:0] div_cnt_q, div_cnt_d;
  logic [2:0] term_q, term_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hisamp_pkg::S_IDLE;
      div_cnt_q <= '0;
      term_q    <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      term_q    <= term_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    term_d    = term_q;
    cmd_o     = '0;
    cmd_o.term = term_q;
    busy      = (state_q != hisamp_pkg::S_IDLE);
    case (state_q)
      hisamp_pkg::S_IDLE: begin
        if (start) begin
          if (kind_i == hisamp_pkg::KIND_DRAW) begin
            cmd_o.draw_ld = 1'b1;
            state_d       = hisamp_pkg::S_GUIDE;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      hisamp_pkg::S_GUIDE: state_d = hisamp_pkg::S_START;
      hisamp_pkg::S_START: begin
        cmd_o.guide_ld = 1'b1;
        state_d        = hisamp_pkg::S_FETCH;
      end
      hisamp_pkg::S_FETCH: state_d = hisamp_pkg::S_CHECK;
      hisamp_pkg::S_CHECK: begin
        if (sts_i.search_more) begin
          cmd_o.step = 1'b1;
          state_d    = hisamp_pkg::S_FETCH;
        end else begin
          cmd_o.capture = 1'b1;
          div_cnt_d     = '0;
          state_d       = sts_i.div_needed ? hisamp_pkg::S_DIV : hisamp_pkg::S_SQ;
        end
      end
      hisamp_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'(hisamp_pkg::DivSteps - 1)) begin
          state_d = hisamp_pkg::S_SQ;
        end
      end
      hisamp_pkg::S_SQ: begin
        cmd_o.sq_ld = 1'b1;
        state_d     = hisamp_pkg::S_CUBE;
      end
      hisamp_pkg::S_CUBE: begin
        cmd_o.cube_ld = 1'b1;
        term_d        = '0;
        state_d       = hisamp_pkg::S_MULA;
      end
      hisamp_pkg::S_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = hisamp_pkg::S_MULB;
      end
      hisamp_pkg::S_MULB: begin
        cmd_o.mul_b = 1'b1;
        if (term_q == hisamp_pkg::LastTerm) begin
          state_d = hisamp_pkg::S_DONE;
        end else begin
          term_d  = term_q + 3'd1;
          state_d = hisamp_pkg::S_MULA;
        end
      end
      hisamp_pkg::S_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = hisamp_pkg::S_IDLE;
      end
      default: state_d = hisamp_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hisamp_dp.sv =====
// ----------------------------------------------------------------------------
// hisamp_dp
// tables, interval search, restoring divider, shared multiplier, accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module hisamp_dp #(
  parameter int MAX_INTERVALS = 256,
  parameter int GUIDE_LENGTH  = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hisamp_pkg::cmd_t  cmd_i,
  output hisamp_pkg::sts_t       sts_o,
  input  wire hisamp_pkg::in_t   item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [8:0]        cfg_wdata_i,
  output hisamp_pkg::out_t       result_o,
  output logic                   result_valid_o
);

  localparam int IW  = $clog2(MAX_INTERVALS);
  localparam int GW  = $clog2(GUIDE_LENGTH);
  localparam int GLW = $clog2(GUIDE_LENGTH + 1);

  function automatic logic [47:0] sat48(logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      return 48'h7FFF_FFFF_FFFF;
    end else if (v < -50'sh0_8000_0000_0000) begin
      return 48'h8000_0000_0000;
    end else begin
      return v[47:0];
    end
  endfunction

  logic [8:0]        icount_q;
  logic [31:0]       u_q;
  logic [GW-1:0]     g_q;
  logic [IW-1:0]     cnt_m1_q;
  logic [IW-1:0]     i_q;
  logic [32:0]       r_q, d_q, t_q, sq_q, cube_q;
  logic [63:0]       p_q;
  logic signed [49:0] acc_inv_q, acc_dens_q;
  hisamp_pkg::out_t  result_q;
  logic              valid_q;

  logic [65:0]  bounds_rd;
  logic [191:0] inv_rd, dens_rd;
  logic [7:0]   guide_rd;

  logic we_inv, we_dens, we_guide;
  logic slot_iv_ok, slot_g_ok;

  assign slot_iv_ok = 32'(item_i.slot) < MAX_INTERVALS;
  assign slot_g_ok  = 32'(item_i.slot) < GUIDE_LENGTH;
  assign we_inv   = cmd_i.load && item_i.kind == hisamp_pkg::KIND_INV && slot_iv_ok;
  assign we_dens  = cmd_i.load && item_i.kind == hisamp_pkg::KIND_DENS && slot_iv_ok;
  assign we_guide = cmd_i.load && item_i.kind == hisamp_pkg::KIND_GUIDE && slot_g_ok;

  hisamp_ram #(.WIDTH(2 * hisamp_pkg::BoundW), .DEPTH(MAX_INTERVALS)) u_bounds (
    .clk_i, .we_i(we_inv), .waddr_i(IW'(item_i.slot)),
    .wdata_i({item_i.cdf_high, item_i.cdf_low}), .raddr_i(i_q), .rdata_o(bounds_rd)
  );

  hisamp_ram #(.WIDTH(4 * hisamp_pkg::CoefW), .DEPTH(MAX_INTERVALS)) u_inv (
    .clk_i, .we_i(we_inv), .waddr_i(IW'(item_i.slot)),
    .wdata_i({item_i.coef3, item_i.coef2, item_i.coef1, item_i.coef0}),
    .raddr_i(i_q), .rdata_o(inv_rd)
  );

  hisamp_ram #(.WIDTH(4 * hisamp_pkg::CoefW), .DEPTH(MAX_INTERVALS)) u_dens (
    .clk_i, .we_i(we_dens), .waddr_i(IW'(item_i.slot)),
    .wdata_i({item_i.coef3, item_i.coef2, item_i.coef1, item_i.coef0}),
    .raddr_i(i_q), .rdata_o(dens_rd)
  );

  hisamp_ram #(.WIDTH(8), .DEPTH(GUIDE_LENGTH)) u_guide (
    .clk_i, .we_i(we_guide), .waddr_i(GW'(item_i.slot)),
    .wdata_i(item_i.guide_start), .raddr_i(g_q), .rdata_o(guide_rd)
  );

  // draw setup
  logic [32+GLW-1:0] gprod;
  int                cnt_c;
  assign gprod = (32 + GLW)'(item_i.uniform) * (32 + GLW)'(GUIDE_LENGTH);

  always_comb begin
    if (icount_q == 9'd0) begin
      cnt_c = 1;
    end else if (32'(icount_q) > MAX_INTERVALS) begin
      cnt_c = MAX_INTERVALS;
    end else begin
      cnt_c = 32'(icount_q);
    end
  end

  // search and normalize setup
  logic [32:0] hi, lo, u33, n_c, d_c;
  logic        zero_case, one_case;
  assign hi  = bounds_rd[65:33];
  assign lo  = bounds_rd[32:0];
  assign u33 = {1'b0, u_q};
  assign n_c = u33 - lo;
  assign d_c = hi - lo;
  assign zero_case = (hi <= lo) || (u33 <= lo);
  assign one_case  = n_c >= d_c;
  assign sts_o.search_more = (i_q < cnt_m1_q) && (hi < u33);
  assign sts_o.div_needed  = !zero_case && !one_case;

  // divider step
  logic [33:0] r2;
  logic        qbit;
  assign r2   = {r_q, 1'b0};
  assign qbit = r2 >= {1'b0, d_q};

  // term select
  logic signed [47:0] coef;
  logic [32:0]        tp;
  always_comb begin
    case (cmd_i.term)
      3'd0:    begin coef = inv_rd[95:48];    tp = t_q;    end
      3'd1:    begin coef = inv_rd[143:96];   tp = sq_q;   end
      3'd2:    begin coef = inv_rd[191:144];  tp = cube_q; end
      3'd3:    begin coef = dens_rd[95:48];   tp = t_q;    end
      3'd4:    begin coef = dens_rd[143:96];  tp = sq_q;   end
      3'd5:    begin coef = dens_rd[191:144]; tp = cube_q; end
      default: begin coef = '0;               tp = '0;     end
    endcase
  end

  logic        neg;
  logic [47:0] mag;
  assign neg = coef[47];
  assign mag = neg ? 48'(-coef) : 48'(coef);

  // shared 32x32 multiplier
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  always_comb begin
    ma = t_q[31:0];
    mb = t_q[31:0];
    if (cmd_i.cube_ld) begin
      ma = sq_q[31:0];
    end else if (cmd_i.mul_a) begin
      ma = mag[47:16];
      mb = tp[31:0];
    end
  end
  assign mprod = 64'(ma) * 64'(mb);

  logic [79:0]        full;
  logic [47:0]        rmag;
  logic signed [47:0] term;
  assign full = {p_q, 16'd0} + 80'(48'(mag[15:0]) * 48'(tp[31:0]));
  assign rmag = full[79:32];
  assign term = tp[32] ? coef : (neg ? 48'(-rmag) : rmag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icount_q <= 9'd1;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        icount_q <= cfg_wdata_i;
      end
      valid_q <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_ld) begin
      u_q      <= item_i.uniform;
      g_q      <= gprod[32 +: GW];
      cnt_m1_q <= IW'(cnt_c - 1);
    end
    if (cmd_i.guide_ld) begin
      i_q <= (32'(guide_rd) > 32'(cnt_m1_q)) ? cnt_m1_q : IW'(guide_rd);
    end else if (cmd_i.step) begin
      i_q <= i_q + IW'(1);
    end
    if (cmd_i.capture) begin
      r_q        <= n_c;
      d_q        <= d_c;
      t_q        <= (!zero_case && one_case) ? hisamp_pkg::OneQ32 : '0;
      acc_inv_q  <= 50'(signed'(inv_rd[47:0]));
      acc_dens_q <= 50'(signed'(dens_rd[47:0]));
    end
    if (cmd_i.div_step) begin
      r_q <= qbit ? 33'(r2 - {1'b0, d_q}) : r2[32:0];
      t_q <= {t_q[31:0], qbit};
    end
    if (cmd_i.sq_ld) begin
      sq_q <= t_q[32] ? t_q : {1'b0, mprod[63:32]};
    end
    if (cmd_i.cube_ld) begin
      cube_q <= t_q[32] ? sq_q : {1'b0, mprod[63:32]};
    end
    if (cmd_i.mul_a) begin
      p_q <= mprod;
    end
    if (cmd_i.mul_b) begin
      if (cmd_i.term < 3'd3) begin
        acc_inv_q <= acc_inv_q + 50'(term);
      end else begin
        acc_dens_q <= acc_dens_q + 50'(term);
      end
    end
    if (cmd_i.done) begin
      result_q.variate        <= sat48(acc_inv_q);
      result_q.density        <= sat48(acc_dens_q);
      result_q.interval_index <= 8'(i_q);
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hisamp_chk.sv =====
// ----------------------------------------------------------------------------
// hisamp_chk
// port level checks of the sampler
// ----------------------------------------------------------------------------
`default_nettype none

module hisamp_chk (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire hisamp_pkg::in_t  item_i,
  input wire logic             result_valid_o
);

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.kind == hisamp_pkg::KIND_DRAW |=> busy)
    else $error("draw did not raise busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.kind != hisamp_pkg::KIND_DRAW |=> !busy)
    else $error("load raised busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back to back results");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(busy))
    else $error("result without a finished draw");

endmodule

bind hermite_inverse_cdf_sampler_top hisamp_chk u_chk (
  .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o
);

`default_nettype wire

// ===== bench/hermite_inverse_cdf_sampler_top_tb.sv =====
// ----------------------------------------------------------------------------
// hermite_inverse_cdf_sampler_top_tb
// self-checking bench for the hermite inverse cdf sampler
//
// a short table of directed items runs first, with a few results typed in,
// then full tables are loaded and random draws and reloads run under
// several interval counts. every untyped draw is predicted by a bit-exact model
// of the guide lookup, forward search, normalization and both cubics.
// ----------------------------------------------------------------------------
`default_nettype none

module hermite_inverse_cdf_sampler_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    NumIntervals = 256;
  localparam int    GuideLen     = 256;
  localparam int    CycleLimit   = 3_000_000;
  localparam longint SatMax      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SatMin      = -64'sh0000_8000_0000_0000;

  typedef struct {
    hisamp_pkg::in_t  item;
    bit               typed;
    hisamp_pkg::out_t want;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  hisamp_pkg::in_t  item_i = '0;
  hisamp_pkg::out_t result_o;
  logic             result_valid_o;
  logic             cfg_we_i = 1'b0;
  logic [8:0]       cfg_wdata_i = '0;

  // predictor state
  logic [8:0]         count_reg;
  logic [32:0]        low_tab  [NumIntervals];
  logic [32:0]        high_tab [NumIntervals];
  logic signed [47:0] inv_tab  [NumIntervals][4];
  logic signed [47:0] dens_tab [NumIntervals][4];
  logic [7:0]         guide_tab[GuideLen];

  hisamp_pkg::out_t draw_queue[$];
  int     errors = 0;
  int     draws = 0;
  int     loads = 0;
  longint cycles = 0;
  logic [32:0] bnd[NumIntervals + 1];

  hermite_inverse_cdf_sampler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint scale_term(logic signed [47:0] a, logic [32:0] t);
    logic [95:0] mag;
    logic [95:0] prod;
    if (t >= hisamp_pkg::OneQ32) return longint'(a);
    mag  = (a < 0) ? 96'(-longint'(a)) : 96'(longint'(a));
    prod = (mag * 96'(t)) >> 32;
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic [32:0] frac_mul(logic [32:0] a, logic [32:0] b);
    logic [65:0] p;
    if (a >= hisamp_pkg::OneQ32) return b;
    if (b >= hisamp_pkg::OneQ32) return a;
    p = 66'(a) * 66'(b);
    return 33'(p >> 32);
  endfunction

  function automatic logic signed [47:0] eval_cubic(logic signed [47:0] c[4],
      logic [32:0] t, logic [32:0] t2, logic [32:0] t3);
    longint s;
    s = longint'(c[0]) + scale_term(c[1], t) + scale_term(c[2], t2)
        + scale_term(c[3], t3);
    if (s > SatMax) s = SatMax;
    if (s < SatMin) s = SatMin;
    return 48'(s);
  endfunction

  // updates the tables, returns 1 with the sample for a draw
  function automatic bit apply_item(hisamp_pkg::in_t it, output hisamp_pkg::out_t res);
    int unsigned cnt, idx;
    logic [32:0] u, lo, hi, t, t2, t3;
    logic [95:0] num;
    res = '0;
    case (it.kind)
      hisamp_pkg::KIND_INV: begin
        low_tab[it.slot]  = it.cdf_low;
        high_tab[it.slot] = it.cdf_high;
        inv_tab[it.slot]  = '{it.coef0, it.coef1, it.coef2, it.coef3};
        return 1'b0;
      end
      hisamp_pkg::KIND_DENS: begin
        dens_tab[it.slot] = '{it.coef0, it.coef1, it.coef2, it.coef3};
        return 1'b0;
      end
      hisamp_pkg::KIND_GUIDE: begin
        guide_tab[it.slot] = it.guide_start;
        return 1'b0;
      end
      default: begin
        cnt = count_reg;
        if (cnt < 1) cnt = 1;
        if (cnt > NumIntervals) cnt = NumIntervals;
        u   = {1'b0, it.uniform};
        idx = guide_tab[it.uniform[31:24]];
        if (idx > cnt - 1) idx = cnt - 1;
        while (idx < cnt - 1 && high_tab[idx] < u) idx++;
        lo = low_tab[idx];
        hi = high_tab[idx];
        if (hi <= lo || u <= lo) t = '0;
        else if (u - lo >= hi - lo) t = hisamp_pkg::OneQ32;
        else begin
          num = 96'(u - lo) << 32;
          t   = 33'(num / 96'(hi - lo));
        end
        t2 = frac_mul(t, t);
        t3 = frac_mul(t2, t);
        res.variate        = eval_cubic(inv_tab[idx], t, t2, t3);
        res.density        = eval_cubic(dens_tab[idx], t, t2, t3);
        res.interval_index = 8'(idx);
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    hisamp_pkg::out_t want;
    if (result_valid_o) begin
      if (draw_queue.size() == 0) begin
        $error("unexpected sample %h", result_o);
        errors++;
      end else begin
        want = draw_queue.pop_front();
        if (result_o.variate !== want.variate) begin
          $error("variate expected %h actual %h", want.variate, result_o.variate);
          errors++;
        end
        if (result_o.density !== want.density) begin
          $error("density expected %h actual %h", want.density, result_o.density);
          errors++;
        end
        if (result_o.interval_index !== want.interval_index) begin
          $error("interval_index expected %h actual %h", want.interval_index,
                 result_o.interval_index);
          errors++;
        end
      end
    end
  end

  task automatic send_item(hisamp_pkg::in_t it, bit typed, hisamp_pkg::out_t typed_want);
    int unsigned gap;
    hisamp_pkg::out_t res;
    bit has_res;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    while (busy) @(negedge clk_i);
    has_res = apply_item(it, res);
    if (has_res) begin
      draw_queue.push_back(typed ? typed_want : res);
      draws++;
    end else begin
      loads++;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (draw_queue.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic set_count(logic [8:0] v);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    count_reg   = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [47:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 48'sh7FFF_FFFF_FFFF;
      1: return -48'sh8000_0000_0000;
      2: return 48'($signed($urandom_range(0, 2000)) - 1000) <<< 24;
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [32:0] rand_bound();
    case ($urandom_range(0, 3))
      0: return 33'd0;
      1: return hisamp_pkg::OneQ32;
      default: return {1'b0, 32'($urandom)};
    endcase
  endfunction

  function automatic hisamp_pkg::in_t rand_fill();
    hisamp_pkg::in_t it;
    it.kind        = hisamp_pkg::kind_e'($urandom_range(0, 3));
    it.slot        = 8'($urandom);
    it.cdf_low     = rand_bound();
    it.cdf_high    = rand_bound();
    it.coef0       = rand_coef();
    it.coef1       = rand_coef();
    it.coef2       = rand_coef();
    it.coef3       = rand_coef();
    it.guide_start = 8'($urandom);
    it.uniform     = $urandom;
    return it;
  endfunction

  function automatic hisamp_pkg::in_t mk(hisamp_pkg::kind_e k, logic [7:0] s,
      logic [32:0] lo, logic [32:0] hi, logic signed [47:0] c0, logic signed [47:0] c1,
      logic [7:0] g, logic [31:0] u);
    hisamp_pkg::in_t it;
    it = '0;
    it.kind = k; it.slot = s; it.cdf_low = lo; it.cdf_high = hi;
    it.coef0 = c0; it.coef1 = c1; it.guide_start = g; it.uniform = u;
    return it;
  endfunction

  function automatic hisamp_pkg::out_t mkout(logic signed [47:0] v, logic signed [47:0] d);
    hisamp_pkg::out_t o;
    o.variate = v; o.density = d; o.interval_index = 8'd0;
    return o;
  endfunction

  task automatic load_interval(int s, bit broken);
    hisamp_pkg::in_t it;
    it = rand_fill();
    it.kind = hisamp_pkg::KIND_INV;
    it.slot = 8'(s);
    if (!broken) begin
      it.cdf_low  = bnd[s];
      it.cdf_high = bnd[s + 1];
    end
    send_item(it, 1'b0, '0);
  endtask

  task automatic load_density(int s);
    hisamp_pkg::in_t it;
    it = rand_fill();
    it.kind = hisamp_pkg::KIND_DENS;
    it.slot = 8'(s);
    send_item(it, 1'b0, '0);
  endtask

  task automatic load_guide(int g, bit noisy);
    hisamp_pkg::in_t it;
    int  back;
    it = rand_fill();
    it.kind = hisamp_pkg::KIND_GUIDE;
    it.slot = 8'(g);
    back = ($urandom_range(0, 19) == 0) ? g : $urandom_range(0, 4);
    it.guide_start = noisy ? 8'($urandom) : 8'((g > back) ? g - back : 0);
    send_item(it, 1'b0, '0);
  endtask

  task automatic random_phase(int n);
    hisamp_pkg::in_t it;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: load_interval($urandom_range(0, 255), $urandom_range(0, 2) == 0);
        1: load_density($urandom_range(0, 255));
        2: load_guide($urandom_range(0, 255), $urandom_range(0, 3) == 0);
        default: begin
          it = rand_fill();
          it.kind = hisamp_pkg::KIND_DRAW;
          case ($urandom_range(0, 7))
            0: it.uniform = 32'd0;
            1: it.uniform = 32'hFFFF_FFFF;
            2: it.uniform = bnd[$urandom_range(1, 255)][31:0];
            default: ;
          endcase
          send_item(it, 1'b0, '0);
        end
      endcase
    end
  endtask

  initial begin
    row_t rows[$];
    logic [8:0] counts[6];
    count_reg = 9'd1;

    // directed table, count at its reset value of one
    rows.push_back('{mk(hisamp_pkg::KIND_INV, 0, 0, hisamp_pkg::OneQ32, 48'sd5 <<< 32,
                        0, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DENS, 0, 0, 0, 48'sd1 <<< 32, 0, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_GUIDE, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_GUIDE, 255, 0, 0, 0, 0, 255, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'd0), 1,
                     mkout(48'sd5 <<< 32, 48'sd1 <<< 32)});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
                     mkout(48'sd5 <<< 32, 48'sd1 <<< 32)});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'h00AB_CDEF), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_INV, 0, 0, hisamp_pkg::OneQ32,
                        48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'd0), 1,
                     mkout(48'sh7FFF_FFFF_FFFF, 48'sd1 <<< 32)});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_INV, 0, 0, hisamp_pkg::OneQ32,
                        -48'sh8000_0000_0000, -48'sh8000_0000_0000, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DENS, 0, 0, 0, 48'sh7FFF_FFFF_FFFF,
                        48'sh7FFF_FFFF_FFFF, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_INV, 0, hisamp_pkg::OneQ32, 0, 48'sd3,
                        48'sd9 <<< 32, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'h0080_0000), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_INV, 0, 33'h4000_0000, 33'h8000_0000,
                        48'sd1 <<< 32, -48'sd2 <<< 32, 0, 0), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'h0000_1000), 0, '0});
    rows.push_back('{mk(hisamp_pkg::KIND_DRAW, 0, 0, 0, 0, 0, 0, 32'hFF00_0000), 0, '0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[r]) send_item(rows[r].item, rows[r].typed, rows[r].want);

    // well-formed partition of [0, 1.0] with jittered bounds
    bnd[0] = '0;
    bnd[NumIntervals] = hisamp_pkg::OneQ32;
    for (int k = 1; k < NumIntervals; k++)
      bnd[k] = (33'(k) << 24) + 33'($urandom_range(0, 2 ** 21)) - 33'(2 ** 20);

    set_count(9'd256);
    for (int s = 0; s < NumIntervals; s++) begin
      load_interval(s, 1'b0);
      load_density(s);
      load_guide(s, 1'b0);
    end

    counts = '{9'd256, 9'd1, 9'd0, 9'd511, 9'($urandom_range(2, 255)), 9'd255};
    foreach (counts[p]) begin
      set_count(counts[p]);
      random_phase(80);
    end

    wait_idle();
    $display("ran %0d draws and %0d table loads over %0d count settings",
             draws, loads, $size(counts) + 2);
    $display("draws spanned guide starts, forward search, clamped and empty intervals");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
